// ===== hw/rtl/ldsch_pkg.sv =====
// ---------------------------------------------------------------------------
// ldsch_pkg: shared constants and types of the LOOK disk scheduler
// Sizes of the request chain, register indexes, state codes and the link
// word that one cell hands to the next.
// ---------------------------------------------------------------------------
`default_nettype none

package ldsch_pkg;

  // Capacity of the request chain and width of a stored track
  localparam int MAX_REQUESTS = 16;
  localparam int TRACK_BITS   = 8;

  // Stored tracks are at least as wide as the 8-bit head register
  localparam int POS_W  = (TRACK_BITS > 8) ? TRACK_BITS : 8;
  localparam int CNT_W  = $clog2(MAX_REQUESTS + 1);
  localparam int IDX_W  = $clog2(MAX_REQUESTS);
  localparam int SEEK_W = 9;

  // Mask applied to an incoming 8-bit track
  localparam logic [7:0] REQ_MASK =
    (TRACK_BITS >= 8) ? 8'hFF : 8'((1 << TRACK_BITS) - 1);

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_START_HEAD = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SWEEP_UP   = CFG_IDX_W'(1);

  typedef logic [POS_W-1:0] track_t;

  // gt: the cell is empty or holds a track above the incoming one
  typedef struct packed {
    logic   gt;
    track_t track;
  } link_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_FIND,
    ST_DRAIN
  } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ldsch_if.sv =====
// ---------------------------------------------------------------------------
// ldsch_if: channel interfaces of the LOOK disk scheduler
// Request, result and configuration write channels, each valid/ready.
// ---------------------------------------------------------------------------
`default_nettype none

interface ldsch_req_if;
  logic       valid;
  logic       ready;
  logic [7:0] request_track;
  logic       batch_end;

  modport source (output valid, request_track, batch_end, input ready);
  modport sink   (input valid, request_track, batch_end, output ready);
endinterface

interface ldsch_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] served_track;
  logic [8:0] seek_total;
  logic       final_service;
  logic       overflow;

  modport source (output valid, served_track, seek_total, final_service, overflow,
                  input ready);
  modport sink   (input valid, served_track, seek_total, final_service, overflow,
                  output ready);
endinterface

interface ldsch_cfg_if;
  import ldsch_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [7:0]           data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/look_disk_scheduler.sv =====
// ---------------------------------------------------------------------------
// look_disk_scheduler: LOOK disk-arm scheduler
// Loads a batch of track requests into a sorted cell chain and serves them
// in LOOK order with a running seek distance.
//
//   channel  dir  word
//   req      in   request_track, batch_end
//   res      out  served_track, seek_total, final_service, overflow
//   cfg      in   index, data (0 start_head, 1 sweep_up)
//
// A request is taken every cycle while loading; the chain inserts in place.
// After the word with batch_end, a find state locates the head split; then
// one result leaves per cycle while res does not stall. The next batch
// loads while the final result still waits in the output register. A
// stall on res holds the drain. Reset is synchronous and needs no sweep of
// the chain.
// ---------------------------------------------------------------------------
`default_nettype none

module look_disk_scheduler (
  input  logic        clk,
  input  logic        rst,
  ldsch_req_if.sink   req,
  ldsch_res_if.source res,
  ldsch_cfg_if.sink   cfg
);
  import ldsch_pkg::*;

  state_t            state;
  state_t            state_next;
  logic [7:0]        start_head;
  logic              sweep_up;
  logic [CNT_W-1:0]  count;
  logic              dropped;
  logic [CNT_W-1:0]  first;
  logic [IDX_W-1:0]  k;
  track_t            pos;
  logic [SEEK_W-1:0] seek;

  logic              out_valid;
  logic [7:0]        out_track;
  logic [SEEK_W-1:0] out_seek;
  logic              out_final;
  logic              out_ovf;

  logic              req_ready;
  logic              find_en;
  logic              step;
  logic              req_fire;
  logic              insert;
  track_t            new_track;
  track_t            head_ext;
  logic [CNT_W-1:0]  chain_first;
  logic [CNT_W-1:0]  k_ext;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  rd_pos;
  logic [IDX_W-1:0]  rd_idx;
  track_t            rd_track;
  track_t            diff;
  logic [SEEK_W-1:0] seek_sum;
  logic              last;

  // Handshakes and insert word
  assign req_fire  = req.valid && req_ready;
  assign insert    = req_fire && (count < CNT_W'(MAX_REQUESTS));
  assign new_track = POS_W'(req.request_track & REQ_MASK);
  assign head_ext  = POS_W'(start_head);
  assign req.ready = req_ready;
  assign cfg.ready = 1'b1;

  ldsch_chain u_chain (
    .clk       (clk),
    .insert    (insert),
    .count     (count),
    .new_track (new_track),
    .head      (head_ext),
    .rd_idx    (rd_idx),
    .rd_track  (rd_track),
    .first     (chain_first)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD: begin
        if (req_fire && req.batch_end) state_next = ST_FIND;
      end
      ST_FIND: state_next = ST_DRAIN;
      ST_DRAIN: begin
        if (step && last) state_next = ST_LOAD;
      end
      default: state_next = ST_LOAD;
    endcase
  end

  // State outputs
  always_comb begin
    req_ready = 1'b0;
    find_en   = 1'b0;
    step      = 1'b0;
    case (state)
      ST_LOAD:  req_ready = 1'b1;
      ST_FIND:  find_en   = 1'b1;
      ST_DRAIN: step      = !out_valid || res.ready;
      default: ;
    endcase
  end

  // LOOK order: map service number k to a chain slot
  always_comb begin
    k_ext = CNT_W'(k);
    rem   = count - first;
    if (sweep_up) begin
      rd_pos = (k_ext < rem) ? first + k_ext : count - CNT_W'(1) - k_ext;
    end else begin
      rd_pos = (k_ext < first) ? first - CNT_W'(1) - k_ext : k_ext;
    end
    rd_idx = rd_pos[IDX_W-1:0];
  end

  // Seek step
  always_comb begin
    diff     = (rd_track >= pos) ? rd_track - pos : pos - rd_track;
    seek_sum = seek + SEEK_W'(diff);
    last     = k_ext == (count - CNT_W'(1));
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      start_head <= '0;
      sweep_up   <= 1'b1;
      count      <= '0;
      dropped    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg.valid) begin
        case (cfg.index)
          REG_START_HEAD: start_head <= cfg.data;
          REG_SWEEP_UP:   sweep_up   <= cfg.data[0];
          default: ;
        endcase
      end
      if (req_fire) begin
        if (insert) count <= count + CNT_W'(1);
        else        dropped <= 1'b1;
      end
      if (step && last) begin
        count   <= '0;
        dropped <= 1'b0;
      end
      if (step)           out_valid <= 1'b1;
      else if (res.ready) out_valid <= 1'b0;
    end
  end

  // Drain sequencer and output word
  always_ff @(posedge clk) begin
    if (find_en) begin
      first <= chain_first;
      k     <= '0;
      pos   <= head_ext;
      seek  <= '0;
    end
    if (step) begin
      k         <= k + IDX_W'(1);
      pos       <= rd_track;
      seek      <= seek_sum;
      out_track <= 8'(rd_track);
      out_seek  <= seek_sum;
      out_final <= last;
      out_ovf   <= dropped;
    end
  end

  assign res.valid         = out_valid;
  assign res.served_track  = out_track;
  assign res.seek_total    = out_seek;
  assign res.final_service = out_final;
  assign res.overflow      = out_ovf;

endmodule

`default_nettype wire

// ===== hw/rtl/ldsch_cell.sv =====
// ---------------------------------------------------------------------------
// ldsch_cell: one slot of the sorted insertion chain
// Holds one track. On insert it keeps its track, takes the new track, or
// takes its left neighbor's track, so the chain stays sorted ascending.
// ---------------------------------------------------------------------------
`default_nettype none

module ldsch_cell (
  input  logic             clk,
  input  logic             occupied,
  input  logic             insert,
  input  ldsch_pkg::track_t new_track,
  input  ldsch_pkg::track_t head,
  input  ldsch_pkg::link_t  prev_link,
  output ldsch_pkg::link_t  link,
  output logic             below
);
  import ldsch_pkg::*;

  track_t track;
  track_t track_next;

  // Compare against the broadcast word and the head
  always_comb begin
    link.gt    = !occupied || (track > new_track);
    link.track = track;
    below      = occupied && (track < head);
  end

  // Left neighbor not above the new word: the new word lands here
  always_comb begin
    track_next = track;
    if (insert && link.gt) begin
      track_next = prev_link.gt ? prev_link.track : new_track;
    end
  end

  always_ff @(posedge clk) begin
    track <= track_next;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ldsch_chain.sv =====
// ---------------------------------------------------------------------------
// ldsch_chain: row of insertion cells
// Keeps the batch sorted, reports how many entries lie below the head and
// reads one entry for the drain sequencer.
// ---------------------------------------------------------------------------
`default_nettype none

module ldsch_chain (
  input  logic                        clk,
  input  logic                        insert,
  input  logic [ldsch_pkg::CNT_W-1:0] count,
  input  ldsch_pkg::track_t           new_track,
  input  ldsch_pkg::track_t           head,
  input  logic [ldsch_pkg::IDX_W-1:0] rd_idx,
  output ldsch_pkg::track_t           rd_track,
  output logic [ldsch_pkg::CNT_W-1:0] first
);
  import ldsch_pkg::*;

  link_t                 links [MAX_REQUESTS+1];
  track_t                tracks [MAX_REQUESTS];
  logic [MAX_REQUESTS-1:0] occ;
  logic [MAX_REQUESTS:0]   below;

  // Cell 0 sees a neighbor that is never above the new word
  assign links[0] = '{gt: 1'b0, track: '0};
  assign below[MAX_REQUESTS] = 1'b0;

  // Occupancy is the filled prefix of the chain
  always_comb begin
    for (int i = 0; i < MAX_REQUESTS; i++) begin
      occ[i] = CNT_W'(i) < count;
    end
  end

  for (genvar g = 0; g < MAX_REQUESTS; g++) begin : g_cell
    ldsch_cell u_cell (
      .clk       (clk),
      .occupied  (occ[g]),
      .insert    (insert),
      .new_track (new_track),
      .head      (head),
      .prev_link (links[g]),
      .link      (links[g+1]),
      .below     (below[g])
    );
    assign tracks[g] = links[g+1].track;
  end

  // Below flags form a prefix of ones; the edge gives the split point
  always_comb begin
    first = '0;
    for (int i = 0; i < MAX_REQUESTS; i++) begin
      if (below[i] && !below[i+1]) begin
        first = first | CNT_W'(i + 1);
      end
    end
  end

  assign rd_track = tracks[rd_idx];

endmodule

`default_nettype wire

// ===== hw/rtl/ldsch_checker.sv =====
// ---------------------------------------------------------------------------
// ldsch_checker: port-level checks of the LOOK disk scheduler
// Watches the request and result channels and is bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module ldsch_checker (
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_ready,
  input logic       req_batch_end,
  input logic       res_valid,
  input logic       res_ready,
  input logic [8:0] res_seek,
  input logic       res_final
);

  // Batch end word: the split search takes the next cycle
  a_find_gap: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_batch_end |=> !req_ready)
    else $error("request taken right after batch end");

  // Back-to-back results of one batch never lose seek distance
  a_seek_grows: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready && !res_final ##1 res_valid |-> res_seek >= $past(res_seek))
    else $error("seek total decreased within a batch");

  // Requests are held off until the batch has produced its final word
  a_drain_blocks: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_final |-> !req_ready)
    else $error("request taken while a batch is still draining");

  // Stalled result word holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_seek) && $stable(res_final))
    else $error("stalled result changed");

endmodule

bind look_disk_scheduler ldsch_checker u_ldsch_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .req_batch_end (req.batch_end),
  .res_valid     (res.valid),
  .res_ready     (res.ready),
  .res_seek      (res.seek_total),
  .res_final     (res.final_service)
);

`default_nettype wire
